FILE: rtl/pga_pkg.sv
package pga_pkg;

  localparam int PAGE_CAPACITY = 32768;
  localparam int COUNT_BITS    = 16;

  localparam int PAGE_W    = 20;
  localparam int REF_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W    = (PAGE_CAPACITY > 1) ? $clog2(PAGE_CAPACITY) : 1;
  localparam int TOP_W     = $clog2(PAGE_CAPACITY + 1);

  localparam logic [PAGE_W:0]     CAP_X     = (PAGE_W + 1)'(PAGE_CAPACITY);
  localparam logic [TOP_W-1:0]    TOP_FULL  = TOP_W'(PAGE_CAPACITY);
  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(PAGE_CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = PAGE_W'(524288);
  localparam logic [PAGE_W-1:0] LAST_PAGE_RST  = PAGE_W'(557056);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_PAGE = 2'd0,
    REG_LAST_PAGE  = 2'd1
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ADD   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_SHARED = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [PAGE_W-1:0] page_number;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] page_out;
    logic [REF_W-1:0]  ref_count;
  } out_item_t;

  // memory request from the sequencer: one write and one read address per cycle
  typedef struct packed {
    logic                  we;
    logic [SLOT_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [SLOT_W-1:0]     raddr;
  } cnt_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [PAGE_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } stk_req_t;

  // first <= page < last and page - first below capacity
  function automatic logic page_in_range(input logic [PAGE_W-1:0] page,
                                         input logic [PAGE_W-1:0] first,
                                         input logic [PAGE_W-1:0] last);
    logic [PAGE_W-1:0] off;
    off = page - first;
    return (page >= first) && (page < last) && ({1'b0, off} < CAP_X);
  endfunction

  function automatic logic [SLOT_W-1:0] page_slot(input logic [PAGE_W-1:0] page,
                                                  input logic [PAGE_W-1:0] first);
    logic [PAGE_W-1:0] off;
    off = page - first;
    return off[SLOT_W-1:0];
  endfunction

  function automatic logic [REF_W-1:0] to_ref(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+REF_W-1:0] t;
    t = {{REF_W{1'b0}}, c};
    return t[REF_W-1:0];
  endfunction

endpackage

FILE: rtl/pga_ram.sv
module pga_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pga_core.sv
module pga_core
  import pga_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  input  logic [PAGE_W-1:0]     first_page,
  input  logic [PAGE_W-1:0]     last_page,
  output cnt_req_t              cnt_req,
  input  logic [COUNT_BITS-1:0] cnt_rdata,
  output stk_req_t              stk_req,
  input  logic [PAGE_W-1:0]     stk_rdata,
  output logic                  out_valid,
  output out_item_t             out_item
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  op_e               op_r;
  logic [PAGE_W-1:0] page_r;
  logic              ok_r;
  logic [SLOT_W-1:0] slot_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic                  accept;
  logic [TOP_W-1:0]      top_dec;
  logic                  pop_ok;
  logic [COUNT_BITS-1:0] c_dec, c_inc;

  assign accept  = (state_r == S_IDLE) && start;
  assign busy    = (state_r != S_IDLE);
  assign top_dec = top_r - TOP_W'(1);
  assign pop_ok  = page_in_range(stk_rdata, first_page, last_page);
  assign c_dec   = (cnt_rdata != '0) ? cnt_rdata - COUNT_BITS'(1) : '0;
  assign c_inc   = (cnt_rdata != COUNT_MAX) ? cnt_rdata + COUNT_BITS'(1) : cnt_rdata;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    top_nxt       = top_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    cnt_req.we    = 1'b0;
    cnt_req.waddr = slot_r;
    cnt_req.wdata = '0;
    cnt_req.raddr = page_slot(in_item.page_number, first_page);
    stk_req.we    = 1'b0;
    stk_req.waddr = top_r[SLOT_W-1:0];
    stk_req.wdata = page_r;
    stk_req.raddr = top_dec[SLOT_W-1:0];

    case (state_r)
      S_CLEAR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = clr_r;
        clr_nxt       = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt          = S_IDLE;
        out_valid_nxt      = 1'b1;
        out_nxt.status     = ST_OK;
        out_nxt.page_out   = '0;
        out_nxt.ref_count  = '0;
        if (op_r == OP_ALLOC) begin
          if (top_r == '0) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            top_nxt          = top_dec;
            out_nxt.page_out = stk_rdata;
            // stale page after a range change: hand it out, leave counts alone
            if (pop_ok) begin
              cnt_req.we        = 1'b1;
              cnt_req.waddr     = page_slot(stk_rdata, first_page);
              cnt_req.wdata     = COUNT_BITS'(1);
              out_nxt.ref_count = to_ref(COUNT_BITS'(1));
            end
          end
        end else if (!ok_r) begin
          out_nxt.status = ST_RANGE;
        end else begin
          case (op_r)
            OP_FREE: begin
              cnt_req.we    = 1'b1;
              cnt_req.wdata = c_dec;
              if (c_dec != '0) begin
                out_nxt.status    = ST_SHARED;
                out_nxt.ref_count = to_ref(c_dec);
              end else if (top_r == TOP_FULL) begin
                out_nxt.status = ST_FULL;
              end else begin
                stk_req.we = 1'b1;
                top_nxt    = top_r + TOP_W'(1);
              end
            end
            OP_ADD: begin
              cnt_req.we        = 1'b1;
              cnt_req.wdata     = c_inc;
              out_nxt.ref_count = to_ref(c_inc);
            end
            default: begin
              out_nxt.ref_count = to_ref(cnt_rdata);
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
    if (accept) begin
      op_r   <= in_item.op;
      page_r <= in_item.page_number;
      ok_r   <= page_in_range(in_item.page_number, first_page, last_page);
      slot_r <= page_slot(in_item.page_number, first_page);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/page_allocator_with_refcount.sv
// Flow: the start transfer registers the command and reads the count/stack memories; the result
// is then computed, written back and registered. No new command is taken before then (busy high).
// Reset: synchronous, active low. Free stack empties and the count table is cleared
// by a sweep over all PAGE_CAPACITY (32768) slots with busy high; config writes still taken.
// Results are strobed for one cycle; the receiver cannot stall.
module page_allocator_with_refcount
  import pga_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  // result channel
  output logic                 out_valid,
  output out_item_t            out_item,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data
);

  // managed page window
  logic [PAGE_W-1:0] first_page_r;
  logic [PAGE_W-1:0] last_page_r;

  cnt_req_t              cnt_req;
  stk_req_t              stk_req;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [PAGE_W-1:0]     stk_rdata;

  // register port never stalls; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= FIRST_PAGE_RST;
      last_page_r  <= LAST_PAGE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_PAGE: first_page_r <= cfg_data;
        REG_LAST_PAGE:  last_page_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: range check, pop/push, count update, result register
  pga_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .first_page (first_page_r),
    .last_page  (last_page_r),
    .cnt_req    (cnt_req),
    .cnt_rdata  (cnt_rdata),
    .stk_req    (stk_req),
    .stk_rdata  (stk_rdata),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  // per-page share counts, indexed by page - first_page
  pga_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAGE_CAPACITY)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_req.we),
    .waddr (cnt_req.waddr),
    .wdata (cnt_req.wdata),
    .raddr (cnt_req.raddr),
    .rdata (cnt_rdata)
  );

  // LIFO of free page numbers; the slot below the top is read, used only when not empty
  pga_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (PAGE_CAPACITY)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

endmodule

FILE: tb/page_allocator_with_refcount_tb.sv
module page_allocator_with_refcount_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pga_pkg::*;

  // Register indexes past the end of the list; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [PAGE_W-1:0]    PAGE_MAX    = '1;
  localparam logic [PAGE_W-1:0]    MID_FIRST   = PAGE_W'(12345);
  localparam int                   MAX_REPORTS = 10;

  // Expected-result store plus a behavioral copy of the allocator state:
  // LIFO of free page numbers, per-page share counts and the page window.
  class alloc_scoreboard;
    logic [PAGE_W-1:0]     first_pg;
    logic [PAGE_W-1:0]     last_pg;
    logic [PAGE_W-1:0]     stacked [PAGE_CAPACITY];
    logic [COUNT_BITS-1:0] share [PAGE_CAPACITY];
    int                    depth;
    out_item_t             awaited [$];
    int                    errors;
    int                    checked;
    int                    status_seen [5];
    int                    sat_hits;
    int                    outside_pops;

    function new();
      first_pg = FIRST_PAGE_RST;
      last_pg  = LAST_PAGE_RST;
      depth    = 0;
      errors   = 0;
      checked  = 0;
      sat_hits = 0;
      outside_pops = 0;
      foreach (share[i]) share[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [PAGE_W-1:0] val);
      case (idx)
        REG_FIRST_PAGE: first_pg = val;
        REG_LAST_PAGE:  last_pg  = val;
        default: ;
      endcase
    endfunction

    // window check; slot is the offset into the count table
    function bit slot_of(input logic [PAGE_W-1:0] page, output logic [SLOT_W-1:0] slot);
      logic [PAGE_W-1:0] off;
      off  = page - first_pg;
      slot = off[SLOT_W-1:0];
      return (page >= first_pg) && (page < last_pg) && (off < PAGE_CAPACITY);
    endfunction

    // Applies one accepted command to the state and queues its result.
    function out_item_t note_command(input in_item_t it);
      out_item_t             r;
      logic [SLOT_W-1:0]     s;
      logic [COUNT_BITS-1:0] c;
      r.status    = ST_OK;
      r.page_out  = '0;
      r.ref_count = '0;
      if (it.op == OP_ALLOC) begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth--;
          r.page_out = stacked[depth];
          if (slot_of(r.page_out, s)) begin
            share[s]    = COUNT_BITS'(1);
            r.ref_count = REF_W'(1);
          end else begin
            outside_pops++;  // window moved after the push
          end
        end
      end else if (!slot_of(it.page_number, s)) begin
        r.status = ST_RANGE;
      end else begin
        c = share[s];
        case (it.op)
          OP_FREE: begin
            if (c != 0) c--;
            share[s] = c;
            if (c != 0) begin
              r.status    = ST_SHARED;
              r.ref_count = c;
            end else if (depth >= PAGE_CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              stacked[depth] = it.page_number;
              depth++;
            end
          end
          OP_ADD: begin
            if (c == COUNT_MAX) sat_hits++;
            else c++;
            share[s]    = c;
            r.ref_count = c;
          end
          default: r.ref_count = c;
        endcase
      end
      awaited.push_back(r);
      return r;
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result status %0d page %h count %0d",
                   $realtime, got.status, got.page_out, got.ref_count);
        return;
      end
      want = awaited.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.status !== want.status || got.page_out !== want.page_out ||
          got.ref_count !== want.ref_count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: result %0d: expected status %0d page %h count %0d,",
                    " got status %0d page %h count %0d"},
                   $realtime, checked, want.status, want.page_out, want.ref_count,
                   got.status, got.page_out, got.ref_count);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAGE_W-1:0]    cfg_data;

  alloc_scoreboard   sb = new();
  out_item_t         last_pred;        // prediction for the latest accepted command
  logic [PAGE_W-1:0] held [$];         // pages handed out, reused for free/add/read
  int                windows;

  page_allocator_with_refcount i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are strobed for one cycle and cannot be held off: take each one
  // at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One command transfer. start stays high across back-to-back commands;
  // with a gap it drops at one falling edge and rises at a later one.
  task automatic send_cmd(input op_e op, input logic [PAGE_W-1:0] page, input int gap);
    in_item_t it;
    it.op          = op;
    it.page_number = page;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_pred = sb.note_command(it);
    if (op == OP_ALLOC && last_pred.status == ST_OK) begin
      held.push_back(last_pred.page_out);
      if (held.size() > 64) void'(held.pop_front());
    end
  endtask

  // Sender holds off until every outstanding result is back, then lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_window(input logic [PAGE_W-1:0] first, input logic [PAGE_W-1:0] last);
    wait_drained();
    cfg_write(REG_FIRST_PAGE, first);
    cfg_write(REG_LAST_PAGE, last);
    windows++;
  endtask

  // Random traffic: mostly pages near the window base or ones already handed
  // out, so counts climb and fall; some window edges and fully random noise.
  task automatic run_random(input int n);
    op_e               op;
    logic [PAGE_W-1:0] page;
    int                r;
    bit                calm;
    calm = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 59) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 25)      op = OP_ALLOC;
      else if (r < 55) op = OP_FREE;
      else if (r < 75) op = OP_ADD;
      else             op = OP_READ;
      r = $urandom_range(0, 99);
      if (r < 40 && held.size() > 0) begin
        page = held[$urandom_range(0, held.size() - 1)];
      end else if (r < 70) begin
        page = sb.first_pg + PAGE_W'($urandom_range(0, 15));
      end else if (r < 85) begin
        case ($urandom_range(0, 5))
          0: page = sb.first_pg - 1'b1;
          1: page = sb.first_pg;
          2: page = sb.last_pg - 1'b1;
          3: page = sb.last_pg;
          4: page = sb.first_pg + PAGE_W'(PAGE_CAPACITY - 1);
          default: page = sb.first_pg + PAGE_W'(PAGE_CAPACITY);
        endcase
      end else begin
        page = PAGE_W'($urandom_range(0, int'(PAGE_MAX)));
      end
      send_cmd(op, page, calm ? 0 : pick_gap());
    end
  endtask

  initial begin
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] top;

    // every input known from time zero
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FIRST_PAGE;
    cfg_data  = '0;
    windows   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Register writes are taken during the clearing sweep; the first command
    // then waits out busy.
    cfg_write(REG_FIRST_PAGE, FIRST_PAGE_RST);
    cfg_write(REG_LAST_PAGE, LAST_PAGE_RST);
    windows++;
    base = FIRST_PAGE_RST;
    top  = LAST_PAGE_RST;

    // Directed: empty stack, window edges, push on zero count, pop,
    // still-shared free, count on a never-allocated page.
    send_cmd(OP_ALLOC, PAGE_MAX, 0);
    send_cmd(OP_READ, base, 0);
    send_cmd(OP_READ, base - 1'b1, 1);
    send_cmd(OP_READ, top, 0);
    send_cmd(OP_ADD, top - 1'b1, 0);
    send_cmd(OP_READ, '0, 2);
    send_cmd(OP_READ, PAGE_MAX, 0);
    send_cmd(OP_FREE, base, 0);
    send_cmd(OP_FREE, base + 1'b1, 0);
    send_cmd(OP_ALLOC, '0, 3);
    send_cmd(OP_ADD, base + 1'b1, 0);
    send_cmd(OP_FREE, base + 1'b1, 0);
    send_cmd(OP_FREE, base + 1'b1, 1);
    send_cmd(OP_FREE, top - 1'b1, 0);
    send_cmd(OP_ALLOC, PAGE_MAX, 0);
    send_cmd(OP_ADD, '0, 0);
    send_cmd(OP_FREE, '0, 0);
    send_cmd(OP_FREE, PAGE_MAX, 0);

    // Slide the window up by one so the bottom stacked page falls outside:
    // it is still popped, with no count written.
    set_window(base + 1'b1, top);
    send_cmd(OP_ALLOC, '0, 0);
    send_cmd(OP_ALLOC, '0, 0);
    send_cmd(OP_ALLOC, '0, 0);
    send_cmd(OP_READ, base, 0);

    // Random traffic across several windows, extremes included; also poke
    // the unused register indexes.
    set_window('0, PAGE_MAX);
    run_random(135);
    set_window(PAGE_MAX, '0);
    cfg_write(REG_SPARE_A, PAGE_W'($urandom_range(0, int'(PAGE_MAX))));
    cfg_write(REG_SPARE_B, PAGE_W'($urandom_range(0, int'(PAGE_MAX))));
    run_random(135);
    set_window(PAGE_MAX - 7'd100, PAGE_MAX);
    run_random(135);
    set_window(MID_FIRST, MID_FIRST + PAGE_W'(PAGE_CAPACITY));
    run_random(135);
    set_window(FIRST_PAGE_RST, LAST_PAGE_RST);
    run_random(135);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d commands over %0d windows: ok %0d, empty %0d, out of range %0d,",
             sb.checked, windows, sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_RANGE]);
    $display("shared %0d, full %0d, saturated adds %0d, pops outside the window %0d",
             sb.status_seen[ST_SHARED], sb.status_seen[ST_FULL], sb.sat_hits,
             sb.outside_pops);
    if (sb.errors == 0) begin
      $display("page_allocator_with_refcount: match");
    end else begin
      $display("page_allocator_with_refcount: mismatch");
    end
    $finish;
  end

  // Slowest legal run is under a millisecond (clearing sweep plus long gaps);
  // give it several times that.
  initial begin
    #5_000_000;
    $display("timeout waiting on the allocator");
    $display("page_allocator_with_refcount: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pga_pkg.sv
rtl/pga_ram.sv
rtl/pga_core.sv
rtl/page_allocator_with_refcount.sv
tb/page_allocator_with_refcount_tb.sv
